[design/gqe_pkg.sv]
// shared types, constants and sine table builder for the glyph quad emitter
package gqe_pkg;

    localparam int MAX_QUADS_DEF   = 256;
    localparam int SINE_BITS_DEF   = 8;
    localparam int COORD_BITS_DEF  = 16;

    localparam int GLYPH_DEPTH     = 256;
    localparam int SW_W            = 20;

    localparam logic [1:0] CMD_BEGIN = 2'd0;
    localparam logic [1:0] CMD_PLACE = 2'd1;
    localparam logic [1:0] CMD_LOAD  = 2'd2;

    localparam logic [1:0] CFG_SPACING = 2'd0;
    localparam logic [1:0] CFG_LEADING = 2'd1;
    localparam logic [1:0] CFG_HEIGHT  = 2'd2;

    localparam logic [7:0]  CHAR_NEWLINE = 8'h0A;
    localparam logic [31:0] COLOR_WHITE  = 32'hFFFF_FFFF;
    localparam logic signed [15:0] ONE_Q14 = 16'sd16384;
    localparam logic [63:0] TWO_PI_Q30   = 64'd6746518852;

    typedef struct packed {
        logic [15:0] v1;
        logic [15:0] u1;
        logic [15:0] v0;
        logic [15:0] u0;
        logic [15:0] h;
        logic [15:0] w;
    } t_glyph;

    // first quadrant sine in q1.14, taylor series in q30
    function automatic logic signed [15:0] quarter_sine(input int r, input int bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic signed [63:0] sum;
        logic [63:0] rnd;
        x    = (64'(r) * TWO_PI_Q30) >> bits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        for (int k = 1; k <= 6; k++) begin
            term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if ((k % 2) == 1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = 64'sd0;
        end
        rnd = ($unsigned(sum) + 64'd32768) >> 16;
        return $signed(rnd[15:0]);
    endfunction

    // full turn table entry, quadrants mirrored
    function automatic logic signed [15:0] sine_entry(input int i, input int bits);
        int q4;
        int quad;
        int r;
        logic signed [15:0] v;
        q4   = 1 << (bits - 2);
        quad = i >> (bits - 2);
        r    = i & (q4 - 1);
        v    = ((quad & 1) != 0) ? quarter_sine(q4 - r, bits) : quarter_sine(r, bits);
        return ((quad & 2) != 0) ? -v : v;
    endfunction

endpackage

[design/gqe_if.sv]
// character and vertex channel interfaces
interface gqe_char_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic [7:0]         char_code;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic               effect_on;
    logic signed [15:0] shift_x;
    logic signed [15:0] shift_y;
    logic [15:0]        effect_scale;
    logic [15:0]        turn_angle;
    logic [31:0]        tint;
    logic [63:0]        glyph_tex;
    logic [31:0]        glyph_size;

    modport source (output valid, cmd, char_code, start_x, start_y, effect_on, shift_x,
                    shift_y, effect_scale, turn_angle, tint, glyph_tex, glyph_size,
                    input ready);
    modport sink (input valid, cmd, char_code, start_x, start_y, effect_on, shift_x,
                  shift_y, effect_scale, turn_angle, tint, glyph_tex, glyph_size,
                  output ready);
endinterface

interface gqe_vert_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] vert_x;
    logic signed [15:0] vert_y;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic [31:0]        vertex_color;
    logic [1:0]         corner;
    logic               last;

    modport source (output valid, vert_x, vert_y, tex_u, tex_v, vertex_color, corner, last,
                    input ready);
    modport sink (input valid, vert_x, vert_y, tex_u, tex_v, vertex_color, corner, last,
                  output ready);
endinterface

[design/glyph_quad_emitter.sv]
// glyph quad emitter top level: command sequencer, pen state and vertex datapath
//
// usage
//   i_in carries one command per beat: begin string (sets pen and line start,
//   clears the quad count), place character, or load glyph table entry.
//   o_out carries vertices, four per placed glyph, corner 0..3 with last on
//   corner 3. the user writes configuration registers (spacing, leading, line
//   height) via i_cfg_we / i_cfg_idx / i_cfg_data only while idle; not enforced.
// timing
//   begin, load, newline and dropped characters are handled in the idle state.
//   a placed glyph is worked through in order (table read, scale multiply, size
//   rounding, two product steps of two multiplies each) and then emits its four
//   vertices; no new character is taken until its last vertex is registered.
//   the glyph table read through its single registered port sets the start.
// reset
//   synchronous active low reset clears pen, line start, quad count and the
//   config registers; the glyph table is not cleared and must be loaded before use.
// stalls
//   while o_out is held off the vertex stage waits and i_in stays not ready;
//   the output register holds the waiting vertex unchanged.
module glyph_quad_emitter #(
    parameter int MAX_QUADS       = gqe_pkg::MAX_QUADS_DEF,
    parameter int SINE_TABLE_BITS = gqe_pkg::SINE_BITS_DEF,
    parameter int COORD_BITS      = gqe_pkg::COORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gqe_char_if.sink    i_in,
    gqe_vert_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import gqe_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int QC_W  = $clog2(MAX_QUADS + 1);
    localparam int PW    = ((CB > 16) ? CB : 16) + 3;   // pen and corner base math
    localparam int MW    = PW + 3;                      // doubled centre plus scaled size
    localparam int PR_W  = SW_W + 17;                   // size times sine
    localparam int SUM_W = ((MW + 14 > PR_W + 1) ? MW + 14 : PR_W + 1) + 2;

    localparam logic signed [PW-1:0] P_HI = {{(PW-CB+1){1'b0}}, {(CB-1){1'b1}}};
    localparam logic signed [PW-1:0] P_LO = ~P_HI;
    localparam logic signed [SUM_W-1:0] S_HI = {{(SUM_W-CB+1){1'b0}}, {(CB-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] S_LO = ~S_HI;
    localparam logic signed [SUM_W-1:0] HALF_Q15 = SUM_W'(16384);

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_SCL, S_P1, S_P2, S_EMIT
    } t_state;

    t_state r_state;

    // configuration
    logic signed [15:0] r_spacing;
    logic signed [15:0] r_leading;
    logic [14:0]        r_height;

    // pen state
    logic signed [CB-1:0] r_pen_x;
    logic signed [CB-1:0] r_pen_y;
    logic signed [CB-1:0] r_line_start;
    logic [QC_W-1:0]      r_qcnt;

    // per glyph working registers
    logic                 r_eff;
    logic [15:0]          r_scale;
    logic [15:0]          r_angle;
    logic [31:0]          r_tint;
    logic signed [PW-1:0] r_gx;
    logic signed [PW-1:0] r_gy;
    logic [31:0]          r_mw;
    logic [31:0]          r_mh;
    logic [SW_W-1:0]      r_sw;
    logic [SW_W-1:0]      r_sh;
    logic signed [MW-1:0] r_mx2;
    logic signed [MW-1:0] r_my2;
    logic signed [PR_W-1:0] r_pwc;
    logic signed [PR_W-1:0] r_phs;
    logic signed [PR_W-1:0] r_pws;
    logic signed [PR_W-1:0] r_phc;
    logic [1:0]           r_corner;

    // output register
    logic               r_ovalid;
    logic signed [15:0] r_vx;
    logic signed [15:0] r_vy;
    logic [15:0]        r_tu;
    logic [15:0]        r_tv;
    logic [31:0]        r_col;
    logic [1:0]         r_ocorner;
    logic               r_olast;

    logic     in_beat;
    logic     is_load;
    logic     is_place;
    t_glyph   wdata;
    t_glyph   ent;
    logic signed [15:0] sn;
    logic signed [15:0] cs;

    logic signed [PW-1:0] pen_x_ext;
    logic signed [PW-1:0] pen_y_ext;
    logic signed [PW-1:0] start_x_sat;
    logic signed [PW-1:0] start_y_sat;
    logic signed [PW-1:0] nl_y;
    logic signed [PW-1:0] adv_x;
    logic [32:0]          mw_rnd;
    logic [32:0]          mh_rnd;
    logic signed [SW_W:0] sw_s;
    logic signed [SW_W:0] sh_s;
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic signed [SUM_W-1:0] sh_x;
    logic signed [SUM_W-1:0] sh_y;
    logic signed [SUM_W-1:0] sat_x;
    logic signed [SUM_W-1:0] sat_y;
    logic                 neg_dx;
    logic                 neg_dy;
    logic                 out_free;

    function automatic logic signed [PW-1:0] sat_p(input logic signed [PW-1:0] v);
        return (v > P_HI) ? P_HI : ((v < P_LO) ? P_LO : v);
    endfunction

    assign in_beat  = i_in.valid && i_in.ready;
    assign is_load  = in_beat && (i_in.cmd == CMD_LOAD);
    assign is_place = in_beat && (i_in.cmd == CMD_PLACE) &&
                      (i_in.char_code != CHAR_NEWLINE) && (r_qcnt < QC_W'(MAX_QUADS));
    assign i_in.ready = (r_state == S_IDLE);

    assign wdata = '{u0: i_in.glyph_tex[15:0],  v0: i_in.glyph_tex[31:16],
                     u1: i_in.glyph_tex[47:32], v1: i_in.glyph_tex[63:48],
                     w: i_in.glyph_size[15:0],  h: i_in.glyph_size[31:16]};

    gqe_glyph_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (is_load),
        .i_re    (is_place),
        .i_addr  (i_in.char_code),
        .i_wdata (wdata),
        .o_rdata (ent)
    );

    gqe_sine_rom #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_sine (
        .i_clk   (i_clk),
        .i_angle (r_angle),
        .o_sin   (sn),
        .o_cos   (cs)
    );

    // pen arithmetic, all saturating to the coordinate range
    assign pen_x_ext   = PW'(r_pen_x);
    assign pen_y_ext   = PW'(r_pen_y);
    assign start_x_sat = sat_p(PW'(i_in.start_x));
    assign start_y_sat = sat_p(PW'(i_in.start_y));
    assign nl_y  = sat_p(pen_y_ext + $signed(PW'(r_height)) + PW'(r_leading));
    assign adv_x = sat_p(pen_x_ext + $signed(PW'(ent.w)) + PW'(r_spacing));

    // scaled size rounds to nearest
    assign mw_rnd = {1'b0, r_mw} + 33'd2048;
    assign mh_rnd = {1'b0, r_mh} + 33'd2048;
    assign sw_s   = $signed({1'b0, r_sw});
    assign sh_s   = $signed({1'b0, r_sh});

    // corner k: x offset negative on the left corners, y offset negative on top
    assign neg_dx = (r_corner == 2'd0) || (r_corner == 2'd3);
    assign neg_dy = (r_corner == 2'd0) || (r_corner == 2'd1);

    always_comb begin
        sum_x = (SUM_W'(r_mx2) <<< 14) + HALF_Q15;
        sum_y = (SUM_W'(r_my2) <<< 14) + HALF_Q15;
        sum_x = neg_dx ? sum_x - SUM_W'(r_pwc) : sum_x + SUM_W'(r_pwc);
        sum_x = neg_dy ? sum_x + SUM_W'(r_phs) : sum_x - SUM_W'(r_phs);
        sum_y = neg_dx ? sum_y - SUM_W'(r_pws) : sum_y + SUM_W'(r_pws);
        sum_y = neg_dy ? sum_y - SUM_W'(r_phc) : sum_y + SUM_W'(r_phc);
    end

    assign sh_x  = sum_x >>> 15;
    assign sh_y  = sum_y >>> 15;
    assign sat_x = (sh_x > S_HI) ? S_HI : ((sh_x < S_LO) ? S_LO : sh_x);
    assign sat_y = (sh_y > S_HI) ? S_HI : ((sh_y < S_LO) ? S_LO : sh_y);

    assign out_free = !r_ovalid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_spacing    <= '0;
            r_leading    <= '0;
            r_height     <= '0;
            r_pen_x      <= '0;
            r_pen_y      <= '0;
            r_line_start <= '0;
            r_qcnt       <= '0;
            r_ovalid     <= 1'b0;
            r_corner     <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SPACING: r_spacing <= $signed(i_cfg_data);
                    CFG_LEADING: r_leading <= $signed(i_cfg_data);
                    CFG_HEIGHT:  r_height  <= i_cfg_data[14:0];
                    default: ;
                endcase
            end

            // the vertex stage reloads the register itself while emitting
            if (r_ovalid && o_out.ready && (r_state != S_EMIT)) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_beat) begin
                        case (i_in.cmd)
                            CMD_BEGIN: begin
                                r_pen_x      <= start_x_sat[CB-1:0];
                                r_line_start <= start_x_sat[CB-1:0];
                                r_pen_y      <= start_y_sat[CB-1:0];
                                r_qcnt       <= '0;
                            end
                            CMD_PLACE: begin
                                if (i_in.char_code == CHAR_NEWLINE) begin
                                    r_pen_x <= r_line_start;
                                    r_pen_y <= nl_y[CB-1:0];
                                end else if (is_place) begin
                                    r_eff   <= i_in.effect_on;
                                    r_scale <= i_in.effect_scale;
                                    r_angle <= i_in.effect_on ? i_in.turn_angle : 16'd0;
                                    r_tint  <= i_in.effect_on ? i_in.tint : COLOR_WHITE;
                                    r_gx    <= i_in.effect_on ?
                                               pen_x_ext + PW'(i_in.shift_x) : pen_x_ext;
                                    r_gy    <= i_in.effect_on ?
                                               pen_y_ext + PW'(i_in.shift_y) : pen_y_ext;
                                    r_state <= S_RD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_RD: begin
                    // table entry is out, pen moves by the unscaled width
                    r_mw    <= 32'(ent.w) * 32'(r_scale);
                    r_mh    <= 32'(ent.h) * 32'(r_scale);
                    r_pen_x <= adv_x[CB-1:0];
                    r_qcnt  <= r_qcnt + 1'b1;
                    r_state <= S_SCL;
                end
                S_SCL: begin
                    r_sw    <= r_eff ? mw_rnd[31:12] : SW_W'(ent.w);
                    r_sh    <= r_eff ? mh_rnd[31:12] : SW_W'(ent.h);
                    r_state <= S_P1;
                end
                S_P1: begin
                    r_pwc   <= PR_W'(sw_s) * PR_W'(cs);
                    r_phs   <= PR_W'(sh_s) * PR_W'(sn);
                    r_mx2   <= (MW'(r_gx) <<< 1) + $signed(MW'(r_sw));
                    r_my2   <= (MW'(r_gy) <<< 1) + $signed(MW'(r_sh));
                    r_state <= S_P2;
                end
                S_P2: begin
                    r_pws    <= PR_W'(sw_s) * PR_W'(sn);
                    r_phc    <= PR_W'(sh_s) * PR_W'(cs);
                    r_corner <= 2'd0;
                    r_state  <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_ovalid  <= 1'b1;
                        r_vx      <= sat_x[15:0];
                        r_vy      <= sat_y[15:0];
                        r_tu      <= neg_dx ? ent.u0 : ent.u1;
                        r_tv      <= neg_dy ? ent.v0 : ent.v1;
                        r_col     <= r_tint;
                        r_ocorner <= r_corner;
                        r_olast   <= (r_corner == 2'd3);
                        r_corner  <= r_corner + 2'd1;
                        if (r_corner == 2'd3) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid        = r_ovalid;
    assign o_out.vert_x       = r_vx;
    assign o_out.vert_y       = r_vy;
    assign o_out.tex_u        = r_tu;
    assign o_out.tex_v        = r_tv;
    assign o_out.vertex_color = r_col;
    assign o_out.corner       = r_ocorner;
    assign o_out.last         = r_olast;

    // the quad counter never passes the limit
    a_qcnt_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qcnt <= QC_W'(MAX_QUADS))
        else $error("quad count beyond limit");

    // corners of one quad follow without a gap once the first is taken
    a_corner_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.ready && !o_out.last |=> o_out.valid)
        else $error("quad corners not back to back");

    // no new input while a quad is still being emitted
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) && (r_corner != 2'd0) |-> !i_in.ready)
        else $error("input taken while emitting");

    // a placed glyph always reaches the vertex stage after the read, scale and product states
    a_place_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_place |-> ##5 (r_state == S_EMIT))
        else $error("placed glyph lost in pipeline");

endmodule

[design/gqe_glyph_mem.sv]
// glyph table memory, one write and one read per cycle on a shared address, registered read
module gqe_glyph_mem (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic            i_re,
    input  logic [7:0]      i_addr,
    input  gqe_pkg::t_glyph i_wdata,
    output gqe_pkg::t_glyph o_rdata
);
    import gqe_pkg::*;

    t_glyph r_mem [GLYPH_DEPTH];
    t_glyph r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/gqe_sine_rom.sv]
// sine and cosine lookup with registered output
module gqe_sine_rom #(
    parameter int SINE_TABLE_BITS = gqe_pkg::SINE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic [15:0]        i_angle,
    output logic signed [15:0] o_sin,
    output logic signed [15:0] o_cos
);
    import gqe_pkg::*;

    localparam int SINE_LEN = 1 << SINE_TABLE_BITS;
    localparam logic [SINE_TABLE_BITS-1:0] QUARTER =
        SINE_TABLE_BITS'(SINE_LEN / 4);

    logic signed [15:0] sine_rom [SINE_LEN];
    logic [SINE_TABLE_BITS-1:0] sin_idx;
    logic [SINE_TABLE_BITS-1:0] cos_idx;
    logic signed [15:0] r_sin;
    logic signed [15:0] r_cos;

    for (genvar gi = 0; gi < SINE_LEN; gi++) begin : g_tab
        localparam logic signed [15:0] ENTRY = sine_entry(gi, SINE_TABLE_BITS);
        assign sine_rom[gi] = ENTRY;
    end

    assign sin_idx = i_angle[15 -: SINE_TABLE_BITS];
    assign cos_idx = sin_idx + QUARTER;

    // zero angle means no rotation at all
    always_ff @(posedge i_clk) begin
        if (i_angle == 16'd0) begin
            r_sin <= 16'sd0;
            r_cos <= ONE_Q14;
        end else begin
            r_sin <= sine_rom[sin_idx];
            r_cos <= sine_rom[cos_idx];
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule
